@@ rtl/tlf_pkg.sv @@
// tlf_pkg: shared types, constants and helpers for the transistor ladder filter
// used by every rtl file; depends on nothing
`default_nettype none

package tlf_pkg;

  localparam int TANH_DEPTH_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  // configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 24;
  localparam int FB_W       = 24;
  localparam int TOL_W      = 16;
  localparam int LIMIT_W    = 7;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd262144;
  localparam logic [FB_W-1:0]    FB_RST    = 24'd1572864;
  localparam logic [TOL_W-1:0]   TOL_RST   = 16'd66;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd100;

  typedef enum logic [1:0] {
    REG_GAIN,
    REG_FB,
    REG_TOL,
    REG_LIMIT
  } tlf_reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [FB_W-1:0]    fb;
    logic [TOL_W-1:0]   tol;
    logic [LIMIT_W-1:0] limit;
  } tlf_cfg_t;

  // datapath widths, q4.27 values in 32 bits
  localparam int VAL_W = 32;
  localparam int MA_W  = 34;
  localparam int MB_W  = 31;
  localparam int MP_W  = MA_W + MB_W;
  localparam int X_W   = 40;
  localparam int SAT_W = 40;

  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sd134217728;

  // physical constants folded into q16 multipliers
  localparam logic signed [MB_W-1:0] K_INV_2VT = 31'sd1260308;
  localparam logic signed [MB_W-1:0] K_INV_2GM = 31'sd686442;
  localparam logic signed [MB_W-1:0] K_INV_6GM = 31'sd228814;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T_MUL,
    ST_T_X,
    ST_T_RLO,
    ST_T_RHI,
    ST_T_IMUL,
    ST_T_FIN,
    ST_I_MUL,
    ST_I_FIN,
    ST_FB_MUL,
    ST_FB_FIN,
    ST_CV_MUL,
    ST_CV_FIN,
    ST_UPD,
    ST_DONE
  } tlf_state_t;

  // order of the operations within one sweep
  typedef enum logic [3:0] {
    SP_TANH_IN,
    SP_INT_N0,
    SP_TANH_C0,
    SP_INT_N1,
    SP_TANH_C1,
    SP_INT_N2,
    SP_TANH_C2,
    SP_INT_V4,
    SP_TANH_C3
  } tlf_step_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh80000000;
    end
    return VAL_W'(v);
  endfunction

endpackage

`default_nettype wire

@@ rtl/tlf_if.sv @@
// tlf_in_if / tlf_out_if: valid-ready channels for samples in and results out
// depends on tlf_pkg
`default_nettype none

interface tlf_in_if import tlf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic                          block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface tlf_out_if import tlf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [LIMIT_W-1:0]            sweeps_used;
  logic                          converged;
  logic                          block_end_res;

  modport source (output valid, output sample_out, output sweeps_used, output converged,
                  output block_end_res, input ready);
  modport sink   (input valid, input sample_out, input sweeps_used, input converged,
                  input block_end_res, output ready);
endinterface

`default_nettype wire

@@ rtl/tlf_cfg.sv @@
// tlf_cfg: apb-style register file for gain, feedback, tolerance and sweep limit
// depends on tlf_pkg
`default_nettype none

module tlf_cfg import tlf_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output tlf_cfg_t                   cfg
);

  tlf_cfg_t     cfg_r;
  tlf_reg_idx_t idx;
  logic         wr_en;

  assign idx    = tlf_reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain  <= GAIN_RST;
      cfg_r.fb    <= FB_RST;
      cfg_r.tol   <= TOL_RST;
      cfg_r.limit <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_GAIN:  cfg_r.gain  <= pwdata[GAIN_W-1:0];
        REG_FB:    cfg_r.fb    <= pwdata[FB_W-1:0];
        REG_TOL:   cfg_r.tol   <= pwdata[TOL_W-1:0];
        REG_LIMIT: cfg_r.limit <= pwdata[LIMIT_W-1:0];
        default:   cfg_r       <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN:  prdata = CFG_DATA_W'(cfg_r.gain);
      REG_FB:    prdata = CFG_DATA_W'(cfg_r.fb);
      REG_TOL:   prdata = CFG_DATA_W'(cfg_r.tol);
      REG_LIMIT: prdata = CFG_DATA_W'(cfg_r.limit);
      default:   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/tlf_tanh_rom.sv @@
// tlf_tanh_rom: tanh table over [0, 8) in q4.27, built at elaboration, registered read
// depends on tlf_pkg
`default_nettype none

module tlf_tanh_rom import tlf_pkg::*; #(
  parameter  int DEPTH = TANH_DEPTH_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                    clk,
  input  wire logic [AW-1:0]           addr,
  output logic signed [VAL_W-1:0]      q
);

  typedef logic signed [VAL_W-1:0] tab_t [DEPTH];

  // exponent step of the series, 16/DEPTH in q31
  localparam logic [63:0] A_STEP = (64'd1 << 35) / 64'(DEPTH);

  // long division by compare and subtract, evaluated at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // entry k = tanh(k*8/DEPTH) = (1 - e^-2x)/(1 + e^-2x), e^-2x stepped by a fixed ratio
  function automatic tab_t build_tab();
    tab_t               t;
    logic [63:0]        term;
    logic [63:0]        r;
    logic [63:0]        e;
    logic [63:0]        num;
    logic [63:0]        den;
    logic signed [63:0] sum;
    term = 64'd1 << 31;
    sum  = 64'sd1 <<< 31;
    e    = 64'd1 << 31;
    for (int n = 1; n <= 12; n++) begin
      term = udiv64((term * A_STEP) >> 31, 64'(n));
      if ((n & 1) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    r = unsigned'(sum);
    for (int k = 0; k < DEPTH; k++) begin
      num  = (64'd1 << 31) - e;
      den  = (64'd1 << 31) + e;
      t[k] = VAL_W'((udiv64(num << 28, den) + 64'd1) >> 1);
      e    = (e * r + (64'd1 << 30)) >> 31;
    end
    return t;
  endfunction

  localparam tab_t TAB = build_tab();

  always_ff @(posedge clk) begin
    q <= TAB[addr];
  end

endmodule

`default_nettype wire

@@ rtl/tlf_mul.sv @@
// tlf_mul: the shared signed multiplier, product registered
// depends on tlf_pkg
`default_nettype none

module tlf_mul import tlf_pkg::*; (
  input  wire logic                    clk,
  input  wire logic signed [MA_W-1:0]  a,
  input  wire logic signed [MB_W-1:0]  b,
  output logic signed [MP_W-1:0]       p
);

  logic signed [MP_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= MP_W'(a) * MP_W'(b);
  end

  assign p = p_r;

endmodule

`default_nettype wire

@@ rtl/tlf_core.sv @@
// tlf_core: sweep sequencer, filter state and result register
// depends on tlf_pkg, tlf_if, tlf_mul and tlf_tanh_rom
`default_nettype none

module tlf_core import tlf_pkg::*; #(
  parameter  int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
  parameter  int SAMPLE_BITS      = SAMPLE_BITS_DEF,
  localparam int LD               = $clog2(TANH_TABLE_DEPTH)
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tlf_cfg_t cfg,
  tlf_in_if.sink        in_ch,
  tlf_out_if.source     out_ch
);

  localparam int SH  = 31 - SAMPLE_BITS;
  localparam int SHP = (SH >= 0) ? SH : 0;
  localparam int SHN = (SH < 0) ? -SH : 0;
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -(64'sd1 <<< (SAMPLE_BITS - 1));

  tlf_state_t state_r, state_nxt;
  tlf_step_t  step_r;

  logic signed [VAL_W-1:0] vin_r, vout_r, v4_r, past_r, t0_r, lo_r;
  logic signed [VAL_W-1:0] s0_r, s1_r, s2_r, s3_r;
  logic signed [VAL_W-1:0] n0_r, n1_r, n2_r;
  logic signed [VAL_W-1:0] c0_r, c1_r, c2_r, c3_r;
  logic signed [X_W-1:0]   x_r;
  logic [LD-1:0]           k_r;
  logic [29:0]             frac_r;
  logic                    neg_r, big_r, last_r;
  logic [LIMIT_W-1:0]      sweeps_r;
  logic                    conv_r, bend_r;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [LIMIT_W-1:0]            out_sweeps_r;
  logic                          out_conv_r, out_bend_r;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [MP_W-1:0]  mul_p;
  logic [LD-1:0]           rom_addr;
  logic signed [VAL_W-1:0] rom_q;

  logic                    in_acc;
  logic signed [63:0]      samp_ext;
  logic signed [VAL_W-1:0] vin_conv;
  logic signed [32:0]      tan_d;
  logic signed [MB_W-1:0]  tan_k;
  logic signed [MA_W-1:0]  int_sum;
  logic signed [VAL_W-1:0] int_s;
  logic [X_W-1:0]          x_mag;
  logic [LD-1:0]           k_of_x;
  logic [29:0]             frac_of_x;
  logic signed [VAL_W-1:0] hi_val;
  logic signed [VAL_W-1:0] y_mag, tanh_res, integ_res;
  logic [24:0]             fb_plus;
  logic [32:0]             past_mag, diff_mag;
  logic signed [32:0]      diff;
  logic [48:0]             conv_lhs;
  logic                    conv_ok;
  logic [LIMIT_W-1:0]      eff_limit, sweeps_inc;
  logic                    slot_free;
  logic signed [63:0]      y_full, y_clamp;

  tlf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tlf_tanh_rom #(
    .DEPTH (TANH_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  // input sample to q4.27
  assign samp_ext = 64'(in_ch.sample_in);
  assign vin_conv = (SH >= 0) ? VAL_W'(samp_ext <<< SHP) : VAL_W'(samp_ext >>> SHN);

  // operands of the current step
  always_comb begin
    tan_d   = '0;
    tan_k   = K_INV_2GM;
    int_sum = '0;
    int_s   = s0_r;
    unique case (step_r)
      SP_TANH_IN: begin
        tan_d = 33'(vin_r) - 33'(vout_r);
        tan_k = K_INV_2VT;
      end
      SP_INT_N0: begin
        int_sum = MA_W'(t0_r) + MA_W'(c0_r);
        int_s   = s0_r;
      end
      SP_TANH_C0: tan_d = 33'(n1_r) - 33'(n0_r);
      SP_INT_N1: begin
        int_sum = MA_W'(c1_r) - MA_W'(c0_r);
        int_s   = s1_r;
      end
      SP_TANH_C1: tan_d = 33'(n2_r) - 33'(n1_r);
      SP_INT_N2: begin
        int_sum = MA_W'(c2_r) - MA_W'(c1_r);
        int_s   = s2_r;
      end
      SP_TANH_C2: tan_d = 33'(v4_r) - 33'(n2_r);
      SP_INT_V4: begin
        int_sum = -MA_W'(c3_r) - MA_W'(c2_r);
        int_s   = s3_r;
      end
      SP_TANH_C3: begin
        tan_d = 33'(v4_r);
        tan_k = K_INV_6GM;
      end
      default: begin
        tan_d = '0;
      end
    endcase
  end

  // table index and 30-bit interpolation fraction
  assign x_mag     = x_r[X_W-1] ? unsigned'(-x_r) : unsigned'(x_r);
  assign k_of_x    = x_mag[29 -: LD];
  assign frac_of_x = x_mag[29:0] << LD;
  assign hi_val    = last_r ? Q_ONE : rom_q;

  assign y_mag     = big_r ? Q_ONE : lo_r + VAL_W'(mul_p >>> 30);
  assign tanh_res  = neg_r ? -y_mag : y_mag;
  assign integ_res = sat32(SAT_W'(mul_p >>> 24) + SAT_W'(int_s));

  assign fb_plus  = {1'b0, cfg.fb} + 25'h80000;
  assign past_mag = past_r[VAL_W-1] ? unsigned'(-33'(past_r)) : unsigned'(33'(past_r));
  assign diff     = 33'(v4_r) - 33'(past_r);
  assign diff_mag = diff[32] ? unsigned'(-diff) : unsigned'(diff);
  assign conv_lhs = {diff_mag, 16'd0};
  assign conv_ok  = conv_lhs <= 49'(unsigned'(mul_p));

  assign eff_limit  = (cfg.limit == '0) ? LIMIT_W'(1) : cfg.limit;
  assign sweeps_inc = sweeps_r + LIMIT_W'(1);

  // result back to the sample format, saturated
  assign y_full  = (SH >= 0) ? (64'(vout_r) >>> SHP) : (64'(vout_r) <<< SHN);
  assign y_clamp = (y_full > SMAX) ? SMAX : ((y_full < SMIN) ? SMIN : y_full);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_T_MUL;
      ST_T_MUL:  state_nxt = ST_T_X;
      ST_T_X:    state_nxt = ST_T_RLO;
      ST_T_RLO:  state_nxt = ST_T_RHI;
      ST_T_RHI:  state_nxt = ST_T_IMUL;
      ST_T_IMUL: state_nxt = ST_T_FIN;
      ST_T_FIN:  state_nxt = (step_r == SP_TANH_C3) ? ST_FB_MUL : ST_I_MUL;
      ST_I_MUL:  state_nxt = ST_I_FIN;
      ST_I_FIN:  state_nxt = ST_T_MUL;
      ST_FB_MUL: state_nxt = ST_FB_FIN;
      ST_FB_FIN: state_nxt = ST_CV_MUL;
      ST_CV_MUL: state_nxt = ST_CV_FIN;
      ST_CV_FIN: begin
        state_nxt = (conv_ok || sweeps_inc >= eff_limit) ? ST_UPD : ST_T_MUL;
      end
      ST_UPD:    state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operands, table address, input ready
  always_comb begin
    mul_a       = '0;
    mul_b       = '0;
    rom_addr    = k_r;
    in_ch.ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_T_MUL: begin
        mul_a = MA_W'(tan_d);
        mul_b = tan_k;
      end
      ST_T_RLO:  rom_addr = k_of_x;
      ST_T_RHI:  rom_addr = k_r + LD'(1);
      ST_T_IMUL: begin
        mul_a = MA_W'(hi_val) - MA_W'(lo_r);
        mul_b = signed'({1'b0, frac_r});
      end
      ST_I_MUL: begin
        mul_a = int_sum;
        mul_b = signed'(MB_W'(cfg.gain));
      end
      ST_FB_MUL: begin
        mul_a = MA_W'(v4_r);
        mul_b = signed'(MB_W'(fb_plus));
      end
      ST_CV_MUL: begin
        mul_a = signed'(MA_W'(past_mag));
        mul_b = signed'(MB_W'(cfg.tol));
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // filter state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= '0;
      s0_r <= '0; s1_r <= '0; s2_r <= '0; s3_r <= '0;
      n0_r <= '0; n1_r <= '0; n2_r <= '0;
      c0_r <= '0; c1_r <= '0; c2_r <= '0; c3_r <= '0;
    end else begin
      unique case (state_r)
        ST_T_FIN: begin
          unique case (step_r)
            SP_TANH_C0: c0_r <= tanh_res;
            SP_TANH_C1: c1_r <= tanh_res;
            SP_TANH_C2: c2_r <= tanh_res;
            SP_TANH_C3: c3_r <= tanh_res;
            default:    c0_r <= c0_r;
          endcase
        end
        ST_I_FIN: begin
          unique case (step_r)
            SP_INT_N0: n0_r <= integ_res;
            SP_INT_N1: n1_r <= integ_res;
            SP_INT_N2: n2_r <= integ_res;
            default:   n0_r <= n0_r;
          endcase
        end
        ST_FB_FIN: vout_r <= sat32(SAT_W'(mul_p >>> 20));
        ST_UPD: begin
          // trapezoidal state update s = 2v - s
          s0_r <= sat32((SAT_W'(n0_r) <<< 1) - SAT_W'(s0_r));
          s1_r <= sat32((SAT_W'(n1_r) <<< 1) - SAT_W'(s1_r));
          s2_r <= sat32((SAT_W'(n2_r) <<< 1) - SAT_W'(s2_r));
          s3_r <= sat32((SAT_W'(v4_r) <<< 1) - SAT_W'(s3_r));
        end
        default: vout_r <= vout_r;
      endcase
    end
  end

  // per-sample working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= SP_TANH_IN;
      sweeps_r <= '0;
      conv_r   <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            vin_r    <= vin_conv;
            bend_r   <= in_ch.block_end;
            v4_r     <= '0;
            past_r   <= '0;
            sweeps_r <= '0;
            conv_r   <= 1'b0;
            step_r   <= SP_TANH_IN;
          end
        end
        ST_T_X:   x_r <= X_W'(mul_p >>> 16);
        ST_T_RLO: begin
          k_r    <= k_of_x;
          frac_r <= frac_of_x;
          neg_r  <= x_r[X_W-1];
          big_r  <= |x_mag[X_W-1:30];
          last_r <= (k_of_x == LD'(TANH_TABLE_DEPTH - 1));
        end
        ST_T_RHI: lo_r <= rom_q;
        ST_T_FIN: begin
          if (step_r == SP_TANH_IN) begin
            t0_r <= tanh_res;
          end
          if (step_r != SP_TANH_C3) begin
            step_r <= tlf_step_t'(step_r + 4'd1);
          end
        end
        ST_I_FIN: begin
          if (step_r == SP_INT_V4) begin
            v4_r <= integ_res;
          end
          step_r <= tlf_step_t'(step_r + 4'd1);
        end
        ST_CV_FIN: begin
          sweeps_r <= sweeps_inc;
          conv_r   <= conv_ok;
          past_r   <= v4_r;
          step_r   <= SP_TANH_IN;
        end
        default: x_r <= x_r;
      endcase
    end
  end

  // result register, filled once the slot is free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && slot_free) begin
      out_sample_r <= SAMPLE_BITS'(y_clamp);
      out_sweeps_r <= sweeps_r;
      out_conv_r   <= conv_r;
      out_bend_r   <= bend_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_out    = out_sample_r;
  assign out_ch.sweeps_used   = out_sweeps_r;
  assign out_ch.converged     = out_conv_r;
  assign out_ch.block_end_res = out_bend_r;

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result raised outside the done state");

  a_sweep_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPD |-> sweeps_r != '0 && (conv_r || sweeps_r == eff_limit))
    else $error("solve ended without convergence before the sweep limit");

  a_tanh_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_T_FIN |-> tanh_res <= Q_ONE && tanh_res >= -Q_ONE)
    else $error("tanh result beyond unity");

endmodule

`default_nettype wire

@@ rtl/transistor_ladder_filter.sv @@
// transistor_ladder_filter: four-stage nonlinear ladder low-pass, one sample in, one out
// depends on tlf_pkg, tlf_if, tlf_cfg and tlf_core
//
//   channel  direction  handshake            payload
//   in_ch    in         valid / ready        sample_in, block_end
//   out_ch   out        valid / ready        sample_out, sweeps_used, converged, block_end_res
//   apb      in / out   psel, penable, pready  paddr, pwdata, prdata
//
// one sample runs from one solver sweep up to the sweep limit; a sweep is five table tanh
// lookups and six multiply steps, all on the one shared multiplier and the single table
// read port
// in_ch.ready is high only while the sequencer is idle; a finished result sits in the output
// register and the solve of the next sample may run while it waits
// reset is synchronous, active low, clears all filter state and restores register defaults;
// the tanh table is constant and needs no fill after reset
`default_nettype none

module transistor_ladder_filter import tlf_pkg::*; #(
  parameter int TANH_TABLE_DEPTH = TANH_DEPTH_DEF,
  parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tlf_in_if.sink                     in_ch,
  tlf_out_if.source                  out_ch,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  tlf_cfg_t cfg;

  tlf_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tlf_core #(
    .TANH_TABLE_DEPTH (TANH_TABLE_DEPTH),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ bench/tb_transistor_ladder_filter.sv @@
// tb_transistor_ladder_filter: self-checking bench for the ladder filter, with a bit-true
// solver predictor, random stalls on both channels and register phases over the apb port
// depends on tlf_pkg, tlf_if and the transistor_ladder_filter rtl
`default_nettype none

module tb_transistor_ladder_filter;
  import tlf_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int DEPTH = TANH_DEPTH_DEF;
  localparam longint QONE_L = 64'sd1 << 27;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic                 be;
  } ladder_req_t;

  typedef struct packed {
    logic signed [SB-1:0] smp;
    logic [LIMIT_W-1:0]   sweeps;
    logic                 conv;
    logic                 be;
  } ladder_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  tlf_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  tlf_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  transistor_ladder_filter #(.TANH_TABLE_DEPTH(DEPTH), .SAMPLE_BITS(SB)) DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [GAIN_W-1:0]  m_gain;
  logic [FB_W-1:0]    m_fb;
  logic [TOL_W-1:0]   m_tol;
  logic [LIMIT_W-1:0] m_limit;
  longint lad_s[4], lad_n[3], lad_c[4], lad_last;
  longint tanh_lut[DEPTH];

  ladder_req_t pending_q[$];
  ladder_res_t expected_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  int hold_reqs = 0, hold_seen = 0;
  int gap_left = 0, stall_left = 0, hold_left = 0;

  function automatic longint sat32_l(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned mag_l(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic void build_tanh_lut();
    longint unsigned a, term, r, e, num, den;
    longint sum;
    a = (64'd1 << 35) / DEPTH;
    term = 64'd1 << 31;
    sum = 64'sd1 << 31;
    e = 64'd1 << 31;
    for (int n = 1; n <= 12; n++) begin
      term = ((term * a) >> 31) / n;
      if (n & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    r = sum;
    for (int k = 0; k < DEPTH; k++) begin
      num = (64'd1 << 31) - e;
      den = (64'd1 << 31) + e;
      tanh_lut[k] = longint'((((num << 28) / den) + 1) >> 1);
      e = (e * r + (64'd1 << 30)) >> 31;
    end
  endfunction

  function automatic longint tanh_fix(longint x);
    longint unsigned m, pos, k;
    longint y, lo, hi, frac;
    m = mag_l(x);
    if (m >= (64'd1 << 30)) begin
      y = QONE_L;
    end else begin
      pos = m * DEPTH;
      k = pos >> 30;
      frac = longint'(pos & ((64'd1 << 30) - 1));
      if (k >= DEPTH) begin
        y = QONE_L;
      end else begin
        lo = tanh_lut[k];
        hi = (k + 1 < DEPTH) ? tanh_lut[k + 1] : QONE_L;
        y = lo + (((hi - lo) * frac) >>> 30);
      end
    end
    return x < 0 ? -y : y;
  endfunction

  function automatic longint integrate(longint sum, longint st);
    return sat32_l(((longint'(m_gain) * sum) >>> 24) + st);
  endfunction

  // solves one sample and advances the filter state
  function automatic ladder_res_t solve_sample(ladder_req_t rq);
    ladder_res_t rs;
    longint vin, vout, v4, past, y;
    int unsigned lim, sweeps;
    bit conv;
    lim = (m_limit == 0) ? 1 : m_limit;
    sweeps = 0;
    conv = 1'b0;
    vin = longint'(rq.smp) * 128;
    vout = lad_last;
    v4 = 0;
    forever begin
      past = v4;
      lad_n[0] = integrate(tanh_fix(((vin - vout) * K_INV_2VT) >>> 16) + lad_c[0], lad_s[0]);
      lad_c[0] = tanh_fix(((lad_n[1] - lad_n[0]) * K_INV_2GM) >>> 16);
      lad_n[1] = integrate(lad_c[1] - lad_c[0], lad_s[1]);
      lad_c[1] = tanh_fix(((lad_n[2] - lad_n[1]) * K_INV_2GM) >>> 16);
      lad_n[2] = integrate(lad_c[2] - lad_c[1], lad_s[2]);
      lad_c[2] = tanh_fix(((v4 - lad_n[2]) * K_INV_2GM) >>> 16);
      v4 = integrate(-lad_c[3] - lad_c[2], lad_s[3]);
      lad_c[3] = tanh_fix((v4 * K_INV_6GM) >>> 16);
      vout = sat32_l((v4 * (longint'(m_fb) + (64'sd1 << 19))) >>> 20);
      sweeps++;
      if (mag_l(v4 - past) * 65536 <= longint'(m_tol) * mag_l(past)) begin
        conv = 1'b1;
        break;
      end
      if (sweeps >= lim) break;
    end
    lad_last = vout;
    for (int i = 0; i < 3; i++) lad_s[i] = sat32_l(2 * lad_n[i] - lad_s[i]);
    lad_s[3] = sat32_l(2 * v4 - lad_s[3]);
    y = vout >>> 7;
    if (y > 64'sd8388607) y = 64'sd8388607;
    if (y < -64'sd8388608) y = -64'sd8388608;
    rs.smp = SB'(y);
    rs.sweeps = LIMIT_W'(sweeps);
    rs.conv = conv;
    rs.be = rq.be;
    return rs;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample_in <= '0;
      in_ch.block_end <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(solve_sample('{in_ch.sample_in, in_ch.block_end}));
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          gap_left <= $urandom_range(0, 8);
          in_ch.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          ladder_req_t rq;
          rq = pending_q.pop_front();
          in_ch.sample_in <= rq.smp;
          in_ch.block_end <= rq.be;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result ready, with random stalls and requested long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= 600;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 8);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: out %0d sweeps %0d", $time,
                 out_ch.sample_out, out_ch.sweeps_used);
        errors++;
      end else begin
        ladder_res_t ex;
        ex = expected_q.pop_front();
        if (out_ch.sample_out !== ex.smp) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, ex.smp, out_ch.sample_out);
          errors++;
        end
        if (out_ch.sweeps_used !== ex.sweeps) begin
          $display("%0t: sweeps_used expected %0d actual %0d", $time, ex.sweeps,
                   out_ch.sweeps_used);
          errors++;
        end
        if (out_ch.converged !== ex.conv) begin
          $display("%0t: converged expected %0b actual %0b", $time, ex.conv, out_ch.converged);
          errors++;
        end
        if (out_ch.block_end_res !== ex.be) begin
          $display("%0t: block_end_res expected %0b actual %0b", $time, ex.be,
                   out_ch.block_end_res);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(tlf_reg_idx_t r, logic [CFG_DATA_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'({r, 2'b00});
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      REG_GAIN:  m_gain = v[GAIN_W-1:0];
      REG_FB:    m_fb = v[FB_W-1:0];
      REG_TOL:   m_tol = v[TOL_W-1:0];
      REG_LIMIT: m_limit = v[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_ch.valid) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic set_cfg(logic [31:0] g, logic [31:0] f, logic [31:0] t, logic [31:0] l);
    wait_idle();
    cfg_write(REG_GAIN, g);
    cfg_write(REG_FB, f);
    cfg_write(REG_TOL, t);
    cfg_write(REG_LIMIT, l);
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 4))
      0: return SB'($urandom);
      1: return SB'($urandom_range(0, 8191)) - SB'(4096);
      2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      default: return SB'($urandom_range(0, 2097151)) - SB'(1048576);
    endcase
  endfunction

  task automatic push_rand(int count);
    for (int i = 0; i < count; i++)
      pending_q.push_back('{rand_sample(), 1'($urandom)});
  endtask

  initial begin
    logic signed [SB-1:0] directed [12];
    directed = '{24'sd0, 24'sh7fffff, 24'sh800000, 24'sd1, -24'sd1,
      24'sh400000, -24'sh400000, 24'sh555555, 24'shaaaaaa, 24'sd0, 24'sh7fffff, 24'sd0};
    build_tanh_lut();
    m_gain = GAIN_RST;
    m_fb = FB_RST;
    m_tol = TOL_RST;
    m_limit = LIMIT_RST;
    for (int i = 0; i < 4; i++) begin
      lad_s[i] = 0;
      lad_c[i] = 0;
    end
    for (int i = 0; i < 3; i++) lad_n[i] = 0;
    lad_last = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults first: step responses and field extremes
    for (int i = 0; i < 12; i++) pending_q.push_back('{directed[i], 1'(i & 1)});
    // limit reached on every sample, and limit zero acting as one
    set_cfg(262144, 1572864, 0, 1);
    for (int i = 0; i < 4; i++) pending_q.push_back('{directed[i], 1'(i & 1)});
    set_cfg(262144, 1572864, 0, 0);
    for (int i = 0; i < 3; i++) pending_q.push_back('{directed[i + 1], 1'b1});
    // above-range limit, loose tolerance, register extremes
    set_cfg(24'hffffff, 24'hffffff, 0, 127);
    for (int i = 0; i < 3; i++) pending_q.push_back('{directed[i], 1'b0});
    set_cfg(0, 0, 16'hffff, 5);
    for (int i = 0; i < 3; i++) pending_q.push_back('{directed[i + 4], 1'b1});

    // random phases, mostly short limits
    for (int p = 0; p < 6; p++) begin
      set_cfg($urandom_range(0, 1) ? $urandom_range(0, 24'hffffff) : $urandom_range(0, 1048576),
              $urandom_range(0, 24'hffffff),
              $urandom_range(0, 3) == 0 ? $urandom_range(0, 16'hffff) : $urandom_range(0, 400),
              $urandom_range(0, 4) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 12));
      if (p == 2) begin
        hold_reqs++;
        push_rand(20);
        wait_idle();
      end
      push_rand(25);
      // sender waits for every result before going on
      while (expected_q.size() > 0 || pending_q.size() > 0 || in_ch.valid) @(negedge clk);
      if (p == 5) quiet = 1'b1;
      push_rand(20);
    end
    wait_idle();
    repeat (4300) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
